### hw/rtl/cbeu_pkg.sv
// ----------------------------------------------------------------------------
// cbeu_pkg
// Shared types, sizes, opcodes and address helpers of the bytecode execute unit.
// ----------------------------------------------------------------------------
package cbeu_pkg;

	localparam int REG_COUNT     = 8;
	localparam int STORE_WORDS   = 256;
	localparam int PROGRAM_WORDS = 65536;

	localparam int REG_AW   = $clog2(REG_COUNT);
	localparam int STORE_AW = $clog2(STORE_WORDS);
	localparam int IP_W     = $clog2(PROGRAM_WORDS);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 2'd1;

	localparam logic [5:0] OP_DEBUG          = 6'd0;
	localparam logic [5:0] OP_CALL_CONSTRUCT = 6'd1;
	localparam logic [5:0] OP_CALL_EXECUTE   = 6'd2;
	localparam logic [5:0] OP_CALL_DESTRUCT  = 6'd3;
	localparam logic [5:0] OP_CALL_PRUNE     = 6'd4;
	localparam logic [5:0] OP_CALL_MODIFY    = 6'd5;
	localparam logic [5:0] OP_JEQ_RES        = 6'd6;
	localparam logic [5:0] OP_JNE_RES        = 6'd7;
	localparam logic [5:0] OP_JEQ_CONST      = 6'd8;
	localparam logic [5:0] OP_JNE_CONST      = 6'd9;
	localparam logic [5:0] OP_JEQ_CONST_IND  = 6'd10;
	localparam logic [5:0] OP_JNE_CONST_IND  = 6'd11;
	localparam logic [5:0] OP_JEQ_STORE_IND  = 6'd12;
	localparam logic [5:0] OP_JNE_STORE_IND  = 6'd13;
	localparam logic [5:0] OP_JMP_ABS        = 6'd14;
	localparam logic [5:0] OP_JMP_REL        = 6'd15;
	localparam logic [5:0] OP_JMP_ABS_IND    = 6'd16;
	localparam logic [5:0] OP_JMP_REL_IND    = 6'd17;
	localparam logic [5:0] OP_JMP_ABS_ST     = 6'd18;
	localparam logic [5:0] OP_JMP_REL_ST     = 6'd19;
	localparam logic [5:0] OP_JMP_ABS_IND_ST = 6'd20;
	localparam logic [5:0] OP_JMP_REL_IND_ST = 6'd21;
	localparam logic [5:0] OP_STORE_RES      = 6'd22;
	localparam logic [5:0] OP_LOAD_RES       = 6'd23;
	localparam logic [5:0] OP_STORE_CONST    = 6'd24;
	localparam logic [5:0] OP_COPY           = 6'd25;
	localparam logic [5:0] OP_SET_RES        = 6'd26;
	localparam logic [5:0] OP_STORE_DATA_PTR = 6'd27;
	localparam logic [5:0] OP_LOAD_STORE_PTR = 6'd28;
	localparam logic [5:0] OP_INCREMENT      = 6'd29;
	localparam logic [5:0] OP_DECREMENT      = 6'd30;
	localparam logic [5:0] OP_LOAD_REG       = 6'd31;
	localparam logic [5:0] OP_SUSPEND        = 6'd32;
	localparam logic [5:0] OP_RETURN         = 6'd33;

	typedef struct packed {
		logic [5:0]         command;
		logic signed [31:0] arg_one;
		logic signed [31:0] arg_two;
		logic signed [31:0] arg_three;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        next_ip;
		logic signed [31:0] result_value;
		logic               suspended;
		logic               call_valid;
		logic [2:0]         call_action;
		logic signed [31:0] call_handler;
		logic signed [31:0] call_argument;
		logic signed [31:0] call_out_pointer;
		logic [31:0]        executed_count;
	} out_item_t;

	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [31:0]         data;
	} store_wr_t;

	typedef struct packed {
		logic                 en;
		logic [REG_AW-1:0]    addr;
		logic [31:0]          data;
		logic [REG_COUNT-1:0] clr;
	} reg_wr_t;

	function automatic logic [STORE_AW-1:0] widx(input logic [31:0] off);
		return STORE_AW'((off >> 2) % STORE_WORDS);
	endfunction

	function automatic logic [REG_AW-1:0] ridx(input logic [31:0] r);
		return REG_AW'(r % REG_COUNT);
	endfunction

	function automatic logic [IP_W-1:0] wrap_ip(input logic [31:0] v);
		return IP_W'(v % PROGRAM_WORDS);
	endfunction

endpackage

### hw/rtl/cbeu_if.sv
// ----------------------------------------------------------------------------
// cbeu channel interfaces
// Valid/ready channels for instructions, results and configuration writes.
// ----------------------------------------------------------------------------
interface cbeu_instr_if import cbeu_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbeu_result_if import cbeu_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbeu_cfg_if import cbeu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/cbeu_ram.sv
// ----------------------------------------------------------------------------
// cbeu_ram
// Two read ports, one write port, registered reads, per-entry valid bits that
// make unwritten or cleared entries read as zero, write-to-read forwarding.
// ----------------------------------------------------------------------------
module cbeu_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             re0,
	input  logic [AW-1:0]    raddr0,
	output logic [WIDTH-1:0] rdata0,
	input  logic             re1,
	input  logic [AW-1:0]    raddr1,
	output logic [WIDTH-1:0] rdata1,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [DEPTH-1:0] clr
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] mem0_q, mem1_q, wd0_q, wd1_q;
	logic             fwd0_q, fwd1_q, zero0_q, zero1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re0) begin
			mem0_q <= mem[raddr0];
			wd0_q  <= wdata;
		end
		if (re1) begin
			mem1_q <= mem[raddr1];
			wd1_q  <= wdata;
		end
	end

	// A read that meets a write or a clear of the same entry at the same edge
	// sees the new contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd0_q  <= 1'b0;
			fwd1_q  <= 1'b0;
			zero0_q <= 1'b1;
			zero1_q <= 1'b1;
		end else begin
			valid_q <= valid_q & ~clr;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re0) begin
				fwd0_q  <= we && (waddr == raddr0);
				zero0_q <= clr[raddr0] || !valid_q[raddr0];
			end
			if (re1) begin
				fwd1_q  <= we && (waddr == raddr1);
				zero1_q <= clr[raddr1] || !valid_q[raddr1];
			end
		end
	end

	assign rdata0 = fwd0_q ? wd0_q : (zero0_q ? '0 : mem0_q);
	assign rdata1 = fwd1_q ? wd1_q : (zero1_q ? '0 : mem1_q);

`ifndef SYNTHESIS
	a_no_write_clear_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !clr[waddr])
		else $error("write and clear of the same entry at one edge");
`endif

endmodule

### hw/rtl/cbeu_exec.sv
// ----------------------------------------------------------------------------
// cbeu_exec
// Instruction decode and execute; holds pointer, result, count and return flag.
// ----------------------------------------------------------------------------
module cbeu_exec import cbeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  in_item_t    item,
	input  logic [31:0] store_base,
	input  logic [31:0] data_base,
	input  logic [31:0] st_a1,
	input  logic [31:0] st_a2,
	input  logic [31:0] st_a3,
	input  logic [31:0] rg_a1,
	input  logic [31:0] rg_a2,
	input  logic [31:0] rg_a3,
	output out_item_t   res,
	output store_wr_t   st_wr,
	output reg_wr_t     rg_wr
);

	logic [IP_W-1:0] ip_q, ip_n, ip_inc;
	logic [31:0]     res_q, res_n, cnt_q, cnt_n;
	logic            rw_q, rw_n;
	logic [31:0]     a1, a2, a3;
	logic            susp, cvalid, take;
	logic [2:0]      cact;

	assign a1 = item.arg_one;
	assign a2 = item.arg_two;
	assign a3 = item.arg_three;
	assign ip_inc = wrap_ip(32'(ip_q) + 32'd1);

	always_comb begin
		ip_n   = ip_inc;
		cnt_n  = cnt_q + 32'd1;
		res_n  = res_q;
		rw_n   = rw_q;
		susp   = 1'b0;
		cvalid = 1'b0;
		cact   = '0;
		take   = 1'b0;
		st_wr  = '{en: 1'b0, addr: widx(a1), data: a2};
		rg_wr  = '{en: 1'b0, addr: ridx(a1), data: store_base + a2, clr: '0};
		case (item.command)
			OP_CALL_CONSTRUCT, OP_CALL_EXECUTE, OP_CALL_DESTRUCT, OP_CALL_PRUNE,
			OP_CALL_MODIFY: begin
				cvalid = 1'b1;
				cact   = 3'(item.command - OP_CALL_CONSTRUCT);
				rg_wr.clr[ridx(a1)] = 1'b1;
				rg_wr.clr[ridx(a2)] = 1'b1;
				rg_wr.clr[ridx(a3)] = 1'b1;
				rw_n = (item.command == OP_CALL_EXECUTE) || (item.command == OP_CALL_PRUNE)
					|| (item.command == OP_CALL_MODIFY);
			end
			OP_JEQ_RES: if (res_q == a2) ip_n = wrap_ip(a1);
			OP_JNE_RES: if (res_q != a2) ip_n = wrap_ip(a1);
			OP_JEQ_CONST: if (a2 == st_a3) ip_n = wrap_ip(a1);
			OP_JNE_CONST: if (a2 != st_a3) ip_n = wrap_ip(a1);
			OP_JEQ_CONST_IND: if (a2 == st_a3) ip_n = wrap_ip(st_a1);
			OP_JNE_CONST_IND: if (a2 != st_a3) ip_n = wrap_ip(st_a1);
			OP_JEQ_STORE_IND: if (st_a2 == st_a3) ip_n = wrap_ip(st_a1);
			OP_JNE_STORE_IND: if (st_a2 != st_a3) ip_n = wrap_ip(st_a1);
			OP_JMP_ABS:     ip_n = wrap_ip(a1);
			OP_JMP_REL:     ip_n = wrap_ip(32'(ip_inc) + a1);
			OP_JMP_ABS_IND: ip_n = wrap_ip(st_a1);
			OP_JMP_REL_IND: ip_n = wrap_ip(32'(ip_inc) + st_a1);
			OP_JMP_ABS_ST, OP_JMP_REL_ST, OP_JMP_ABS_IND_ST, OP_JMP_REL_IND_ST: begin
				take  = 1'b1;
				st_wr = '{en: 1'b1, addr: widx(a2), data: a3};
				case (item.command)
					OP_JMP_ABS_ST:     ip_n = wrap_ip(a1);
					OP_JMP_REL_ST:     ip_n = wrap_ip(32'(ip_inc) + a1);
					OP_JMP_ABS_IND_ST: ip_n = wrap_ip(st_a1);
					default:           ip_n = wrap_ip(32'(ip_inc) + st_a1);
				endcase
			end
			OP_STORE_RES:      st_wr = '{en: 1'b1, addr: widx(a1), data: res_q};
			OP_LOAD_RES:       res_n = st_a1;
			OP_STORE_CONST:    st_wr = '{en: 1'b1, addr: widx(a1), data: a2};
			OP_COPY:           st_wr = '{en: 1'b1, addr: widx(a1), data: st_a2};
			OP_SET_RES:        res_n = a1;
			OP_STORE_DATA_PTR: st_wr = '{en: 1'b1, addr: widx(a1), data: data_base + a2};
			OP_LOAD_STORE_PTR: rg_wr.en = 1'b1;
			OP_INCREMENT:      st_wr = '{en: 1'b1, addr: widx(a1), data: st_a1 + a2};
			OP_DECREMENT:      st_wr = '{en: 1'b1, addr: widx(a1), data: st_a1 - a2};
			OP_LOAD_REG: begin
				rg_wr.en   = 1'b1;
				rg_wr.data = {a2[15:0], 16'h0000} + a3;
			end
			OP_SUSPEND: begin
				ip_n = '0;
				susp = 1'b1;
			end
			OP_RETURN: begin
				// The return command neither advances nor counts.
				ip_n  = ip_q;
				cnt_n = cnt_q;
				if (rw_q) begin
					res_n = a2;
					rw_n  = 1'b0;
				end
			end
			default: ;
		endcase
		st_wr.en    = st_wr.en && fire;
		rg_wr.en    = rg_wr.en && fire;
		rg_wr.clr   = fire ? rg_wr.clr : '0;
		res.next_ip          = 16'(ip_n);
		res.result_value     = res_n;
		res.suspended        = susp;
		res.call_valid       = cvalid;
		res.call_action      = cact;
		res.call_handler     = cvalid ? rg_a1 : '0;
		res.call_argument    = cvalid ? rg_a2 : '0;
		res.call_out_pointer = cvalid ? rg_a3 : '0;
		res.executed_count   = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q  <= '0;
			res_q <= '0;
			cnt_q <= '0;
			rw_q  <= 1'b0;
		end else if (fire) begin
			ip_q  <= ip_n;
			res_q <= res_n;
			cnt_q <= cnt_n;
			rw_q  <= rw_n;
		end
	end

`ifndef SYNTHESIS
	a_store_jump_writes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && take |-> st_wr.en && (st_wr.addr == widx(a2)))
		else $error("jump-and-store did not write its store word");
	a_return_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.command == OP_RETURN) |=> $stable(cnt_q) && $stable(ip_q))
		else $error("return command moved pointer or count");
	a_call_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cvalid |-> (rg_wr.clr != '0) && !rg_wr.en && !st_wr.en)
		else $error("call did not clear exactly its registers");
`endif

endmodule

### hw/rtl/callback_bytecode_execute_unit.sv
// ----------------------------------------------------------------------------
// callback_bytecode_execute_unit
// Executes one fetched bytecode instruction per transfer against a word store
// and a register file held in two-read-port memories.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  instr    | in        | command, arg_one, arg_two, arg_three
//  result   | out       | next_ip, result_value, suspended, call_*, executed_count
//  cfg      | in        | register index and write data, always ready
//
//  On acceptance the store reads the words named by arg_two and arg_three, the
//  register file those named by arg_one and arg_two; the second read fetches
//  arg_one from the store and arg_three from the register file; then the
//  instruction executes and writes. A new instruction can be accepted while one
//  executes but not during its reads, as each memory has only two read ports.
//  Execution waits only while the result register is full and not taken.
//  Reset clears all state at once; store and registers use per-entry valid bits.
// ----------------------------------------------------------------------------
module callback_bytecode_execute_unit import cbeu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cbeu_instr_if.sink          instr,
	cbeu_result_if.source       result,
	cbeu_cfg_if.sink            cfg
);

	logic        busy_q, phase_q, out_valid_q;
	in_item_t    item_s1;
	out_item_t   out_q, exec_res;
	logic [31:0] store_base_q, data_base_q;
	logic [31:0] st_cap_q, rg_cap_q;
	logic [31:0] st_rd0, st_rd1, rg_rd0, rg_rd1;
	logic        accept, fire, second_read;
	store_wr_t   st_wr;
	reg_wr_t     rg_wr;

	assign fire        = busy_q && phase_q && (!out_valid_q || result.ready);
	assign instr.ready = !busy_q || fire;
	assign accept      = instr.valid && instr.ready;
	assign second_read = busy_q && !phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else begin
				if (fire) begin
					busy_q <= 1'b0;
				end
				if (second_read) begin
					phase_q <= 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= instr.data;
		end
		if (second_read) begin
			st_cap_q <= st_rd0;
			rg_cap_q <= rg_rd0;
		end
		if (fire) begin
			out_q <= exec_res;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_base_q <= '0;
			data_base_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_STORE_BASE: store_base_q <= cfg.wdata;
				CFG_DATA_BASE:  data_base_q  <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Store port 0: arg_two then arg_one; port 1: arg_three.
	cbeu_ram #(.DEPTH(STORE_WORDS), .WIDTH(32)) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.re0    (accept || second_read),
		.raddr0 (accept ? widx(instr.data.arg_two) : widx(item_s1.arg_one)),
		.rdata0 (st_rd0),
		.re1    (accept),
		.raddr1 (widx(instr.data.arg_three)),
		.rdata1 (st_rd1),
		.we     (st_wr.en),
		.waddr  (st_wr.addr),
		.wdata  (st_wr.data),
		.clr    ('0)
	);

	// Register file port 0: arg_one then arg_three; port 1: arg_two.
	cbeu_ram #(.DEPTH(REG_COUNT), .WIDTH(32)) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.re0    (accept || second_read),
		.raddr0 (accept ? ridx(instr.data.arg_one) : ridx(item_s1.arg_three)),
		.rdata0 (rg_rd0),
		.re1    (accept),
		.raddr1 (ridx(instr.data.arg_two)),
		.rdata1 (rg_rd1),
		.we     (rg_wr.en),
		.waddr  (rg_wr.addr),
		.wdata  (rg_wr.data),
		.clr    (rg_wr.clr)
	);

	cbeu_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.store_base (store_base_q),
		.data_base  (data_base_q),
		.st_a1      (st_rd0),
		.st_a2      (st_cap_q),
		.st_a3      (st_rd1),
		.rg_a1      (rg_cap_q),
		.rg_a2      (rg_rd1),
		.rg_a3      (rg_rd0),
		.res        (exec_res),
		.st_wr      (st_wr),
		.rg_wr      (rg_wr)
	);

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef SYNTHESIS
	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !phase_q)
		else $error("accepted instruction did not start its reads");
	a_no_accept_mid_read: assert property (@(posedge clk) disable iff (!arst_n)
		second_read |-> !instr.ready)
		else $error("instruction accepted during the second read");
	a_fire_after_reads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> $past(busy_q))
		else $error("execute without a held instruction");
`endif

endmodule

### test/callback_bytecode_execute_unit_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// callback_bytecode_execute_unit_monitor
// Watches the instruction, result and configuration channels of the execute
// unit, keeps its own copy of the machine state, works out the result of each
// instruction transfer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module callback_bytecode_execute_unit_monitor import cbeu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	cbeu_instr_if  instr,
	cbeu_result_if result,
	cbeu_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);

	logic [IP_W-1:0] model_ip;
	logic [31:0]     result_reg;
	logic [31:0]     exec_count;
	logic [31:0]     store_base;
	logic [31:0]     data_base;
	logic [31:0]     gp_regs [REG_COUNT];
	logic [31:0]     mem_words [STORE_WORDS];
	logic            return_wanted;
	out_item_t       pending_results [$];
	int              results_seen;

	// Store operands are byte offsets; the low two bits are dropped.
	function automatic logic [31:0] load_word(input logic [31:0] off);
		return mem_words[off[STORE_AW+1:2]];
	endfunction

	function automatic void store_word(input logic [31:0] off, input logic [31:0] value);
		mem_words[off[STORE_AW+1:2]] = value;
	endfunction

	function automatic out_item_t execute_instr(input in_item_t ins);
		out_item_t         o;
		logic [31:0]       a1, a2, a3;
		logic [IP_W-1:0]   ip;
		logic [REG_AW-1:0] r1, r2, r3;
		o  = '0;
		a1 = ins.arg_one;
		a2 = ins.arg_two;
		a3 = ins.arg_three;
		ip = model_ip;
		if (ins.command == OP_RETURN) begin
			if (return_wanted) begin
				result_reg    = a2;
				return_wanted = 1'b0;
			end
		end else begin
			ip         = ip + 1'b1;
			exec_count = exec_count + 1;
			case (ins.command)
			OP_CALL_CONSTRUCT, OP_CALL_EXECUTE, OP_CALL_DESTRUCT, OP_CALL_PRUNE,
			OP_CALL_MODIFY: begin
				r1 = a1[REG_AW-1:0];
				r2 = a2[REG_AW-1:0];
				r3 = a3[REG_AW-1:0];
				o.call_valid       = 1'b1;
				o.call_action      = 3'(ins.command - OP_CALL_CONSTRUCT);
				// All three values are read before any register is cleared.
				o.call_handler     = gp_regs[r1];
				o.call_argument    = gp_regs[r2];
				o.call_out_pointer = gp_regs[r3];
				gp_regs[r1] = '0;
				gp_regs[r2] = '0;
				gp_regs[r3] = '0;
				return_wanted = (ins.command == OP_CALL_EXECUTE) ||
					(ins.command == OP_CALL_PRUNE) || (ins.command == OP_CALL_MODIFY);
			end
			OP_JEQ_RES: if (result_reg == a2) ip = a1[IP_W-1:0];
			OP_JNE_RES: if (result_reg != a2) ip = a1[IP_W-1:0];
			OP_JEQ_CONST: if (a2 == load_word(a3)) ip = a1[IP_W-1:0];
			OP_JNE_CONST: if (a2 != load_word(a3)) ip = a1[IP_W-1:0];
			OP_JEQ_CONST_IND: if (a2 == load_word(a3)) ip = IP_W'(load_word(a1));
			OP_JNE_CONST_IND: if (a2 != load_word(a3)) ip = IP_W'(load_word(a1));
			OP_JEQ_STORE_IND:
				if (load_word(a2) == load_word(a3)) ip = IP_W'(load_word(a1));
			OP_JNE_STORE_IND:
				if (load_word(a2) != load_word(a3)) ip = IP_W'(load_word(a1));
			OP_JMP_ABS: ip = a1[IP_W-1:0];
			OP_JMP_REL: ip = ip + a1[IP_W-1:0];
			OP_JMP_ABS_IND: ip = IP_W'(load_word(a1));
			OP_JMP_REL_IND: ip = ip + IP_W'(load_word(a1));
			// The jump target is read before the store is written.
			OP_JMP_ABS_ST: begin
				ip = a1[IP_W-1:0];
				store_word(a2, a3);
			end
			OP_JMP_REL_ST: begin
				ip = ip + a1[IP_W-1:0];
				store_word(a2, a3);
			end
			OP_JMP_ABS_IND_ST: begin
				ip = IP_W'(load_word(a1));
				store_word(a2, a3);
			end
			OP_JMP_REL_IND_ST: begin
				ip = ip + IP_W'(load_word(a1));
				store_word(a2, a3);
			end
			OP_STORE_RES: store_word(a1, result_reg);
			OP_LOAD_RES: result_reg = load_word(a1);
			OP_STORE_CONST: store_word(a1, a2);
			OP_COPY: store_word(a1, load_word(a2));
			OP_SET_RES: result_reg = a1;
			OP_STORE_DATA_PTR: store_word(a1, data_base + a2);
			OP_LOAD_STORE_PTR: gp_regs[a1[REG_AW-1:0]] = store_base + a2;
			OP_INCREMENT: store_word(a1, load_word(a1) + a2);
			OP_DECREMENT: store_word(a1, load_word(a1) - a2);
			OP_LOAD_REG: gp_regs[a1[REG_AW-1:0]] = {a2[15:0], 16'h0000} + a3;
			OP_SUSPEND: begin
				ip            = '0;
				o.suspended   = 1'b1;
			end
			default: ;
			endcase
		end
		model_ip         = ip;
		o.next_ip        = model_ip;
		o.result_value   = result_reg;
		o.executed_count = exec_count;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
	endtask

	task automatic compare_result(input out_item_t got, input out_item_t want);
		check_field("next_ip", 32'(got.next_ip), 32'(want.next_ip));
		check_field("result_value", got.result_value, want.result_value);
		check_field("suspended", 32'(got.suspended), 32'(want.suspended));
		check_field("call_valid", 32'(got.call_valid), 32'(want.call_valid));
		check_field("call_action", 32'(got.call_action), 32'(want.call_action));
		check_field("call_handler", got.call_handler, want.call_handler);
		check_field("call_argument", got.call_argument, want.call_argument);
		check_field("call_out_pointer", got.call_out_pointer, want.call_out_pointer);
		check_field("executed_count", got.executed_count, want.executed_count);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_ip      = '0;
			result_reg    = '0;
			exec_count    = '0;
			store_base    = '0;
			data_base     = '0;
			return_wanted = 1'b0;
			results_seen  = 0;
			mismatches    = 0;
			foreach (gp_regs[i]) gp_regs[i] = '0;
			foreach (mem_words[i]) mem_words[i] = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_STORE_BASE: store_base = cfg.wdata;
				CFG_DATA_BASE: data_base = cfg.wdata;
				default: ;
				endcase
			end
			if (instr.valid && instr.ready)
				pending_results.push_back(execute_instr(instr.data));
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0)
					report_mismatch("result transfer with no instruction outstanding");
				else
					compare_result(result.data, pending_results.pop_front());
				results_seen++;
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

### test/callback_bytecode_execute_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// callback_bytecode_execute_unit_tb
// Drives instruction sequences and base address writes into the execute unit,
// with random instruction and result gaps, and lets the monitor check every result.
// ----------------------------------------------------------------------------
module callback_bytecode_execute_unit_tb import cbeu_pkg::*; ();

	localparam int         STALL_LIMIT     = 4000;
	localparam int         PHASE_ITEMS     = 405;
	localparam logic [5:0] OP_UNUSED_FIRST = 6'd34;
	localparam logic [5:0] OP_UNUSED_LAST  = 6'd63;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   sent_items;
	int   idle_cycles = 0;
	bit   quiet;

	logic [31:0] value_pool [8];

	cbeu_instr_if  instr_ch ();
	cbeu_result_if result_ch ();
	cbeu_cfg_if    cfg_ch ();

	callback_bytecode_execute_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	callback_bytecode_execute_unit_monitor i_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; none at all in quiet stretches.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'h8000_0000;
		3: return 32'h7FFF_FFFF;
		4, 5: return value_pool[$urandom_range(0, 7)];
		6: return $urandom_range(0, 15);
		default: return $urandom();
		endcase
	endfunction

	// Byte offset into the store: usually one of a few words, with random high
	// and low bits that the store ignores.
	function automatic logic [31:0] pick_offset();
		logic [31:0] off;
		off = $urandom();
		if ($urandom_range(0, 3) != 0)
			off[STORE_AW+1:2] = STORE_AW'($urandom_range(0, 7));
		return off;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 2))
		0: return pick_offset();
		1: return pick_value();
		default: return $urandom();
		endcase
	endfunction

	task automatic send_op(input logic [5:0] cmd, input logic [31:0] a1,
		input logic [31:0] a2, input logic [31:0] a3);
		int       gap;
		in_item_t item;
		item.command   = cmd;
		item.arg_one   = a1;
		item.arg_two   = a2;
		item.arg_three = a3;
		gap = idle_gap();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data  <= item;
		do @(posedge clk); while (!instr_ch.ready);
		sent_items++;
		if ($urandom_range(0, 59) == 0)
			quiet = !quiet;
	endtask

	// The monitor's count is registered, so it lags the last instruction transfer.
	task automatic drain();
		instr_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_bases(input logic [31:0] store_addr, input logic [31:0] data_addr);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_STORE_BASE;
		cfg_ch.wdata <= store_addr;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_DATA_BASE;
		cfg_ch.wdata <= data_addr;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_op();
		logic [5:0] cmd;
		if ($urandom_range(0, 19) == 0)
			cmd = 6'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else
			cmd = 6'($urandom_range(OP_DEBUG, OP_RETURN));
		send_op(cmd, pick_operand(), pick_operand(), pick_operand());
	endtask

	// Load a few registers, issue a call on them, and usually answer it.
	task automatic call_sequence();
		logic [31:0] regs [3];
		logic [5:0]  call_op;
		for (int i = 0; i < 3; i++) begin
			regs[i] = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 7);
			if ($urandom_range(0, 2) == 0)
				send_op(OP_LOAD_STORE_PTR, regs[i], pick_value(), pick_operand());
			else
				send_op(OP_LOAD_REG, regs[i], pick_value(), pick_value());
		end
		call_op = OP_CALL_CONSTRUCT + 6'($urandom_range(0, 4));
		send_op(call_op, regs[$urandom_range(0, 2)], regs[$urandom_range(0, 2)],
			($urandom_range(0, 4) == 0) ? $urandom() : regs[2]);
		repeat ($urandom_range(0, 3)) random_op();
		if ($urandom_range(0, 4) != 0)
			send_op(OP_RETURN, pick_operand(), pick_value(), pick_operand());
	endtask

	// Set the result or a store word, then branch on it.
	task automatic compare_sequence();
		logic [31:0] off;
		logic [31:0] value;
		logic [5:0]  cmd;
		off   = pick_offset();
		value = pick_value();
		case ($urandom_range(0, 3))
		0: send_op(OP_SET_RES, value, pick_operand(), pick_operand());
		1: send_op(OP_COPY, off, pick_offset(), pick_operand());
		default: send_op(OP_STORE_CONST, off, value, pick_operand());
		endcase
		cmd = 6'($urandom_range(OP_JEQ_RES, OP_JNE_STORE_IND));
		if (cmd >= OP_JEQ_STORE_IND)
			send_op(cmd, pick_offset(), pick_offset(), off);
		else
			send_op(cmd, ($urandom_range(0, 1) != 0) ? pick_offset() : $urandom(), value, off);
	endtask

	task automatic directed_part();
		send_op(OP_SET_RES, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_op(OP_JEQ_RES, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		send_op(OP_JNE_RES, 32'h7, 32'h7FFF_FFFF, 32'h0);
		send_op(OP_STORE_CONST, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
		send_op(OP_JEQ_CONST, 32'h1234, 32'h8000_0000, 32'h3FF);
		send_op(OP_JNE_CONST, 32'h55, 32'h8000_0000, 32'hFFFF_FFFD);
		send_op(OP_STORE_CONST, 32'h0, 32'd40, 32'h0);
		send_op(OP_JEQ_CONST_IND, 32'h0, 32'h8000_0000, 32'h3FC);
		send_op(OP_JNE_CONST_IND, 32'h0, 32'h8000_0000, 32'h3FC);
		send_op(OP_JEQ_STORE_IND, 32'h0, 32'hFFFF_FFFC, 32'h3FC);
		send_op(OP_JNE_STORE_IND, 32'h0, 32'h0, 32'h400);
		send_op(OP_JMP_ABS, 32'h0001_FFFF, 32'h0, 32'h0);
		send_op(OP_JMP_REL, 32'h1, 32'h0, 32'h0);
		send_op(OP_JMP_REL, 32'h8000_0000, 32'h0, 32'h0);
		send_op(OP_JMP_ABS_IND, 32'h3, 32'h0, 32'h0);
		send_op(OP_JMP_REL_IND, 32'h0, 32'h0, 32'h0);
		send_op(OP_JMP_ABS_ST, 32'h5, 32'h8, 32'hFFFF_FFFF);
		send_op(OP_JMP_REL_ST, 32'hFFFF_FFFE, 32'hC, 32'h8000_0000);
		send_op(OP_JMP_ABS_IND_ST, 32'hC, 32'h10, 32'h7FFF_FFFF);
		send_op(OP_JMP_REL_IND_ST, 32'h8, 32'h14, 32'h1);
		send_op(OP_STORE_RES, 32'h18, 32'h0, 32'h0);
		send_op(OP_LOAD_RES, 32'hC, 32'h0, 32'h0);
		send_op(OP_COPY, 32'h1C, 32'h10, 32'h0);
		send_op(OP_STORE_DATA_PTR, 32'h20, 32'h1, 32'h0);
		send_op(OP_LOAD_STORE_PTR, 32'hFFFF_FFFF, 32'h10, 32'h0);
		send_op(OP_INCREMENT, 32'h8, 32'h1, 32'h0);
		send_op(OP_DECREMENT, 32'h4, 32'h7FFF_FFFF, 32'h0);
		send_op(OP_LOAD_REG, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_LOAD_REG, 32'h2, 32'h0000_1234, 32'h8000_0000);
		// Register 7 is named twice; the request still carries its old value.
		send_op(OP_CALL_EXECUTE, 32'h7, 32'h1, 32'hFFFF_FFFF);
		send_op(OP_DEBUG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_RETURN, 32'h0, 32'h8000_0000, 32'h0);
		send_op(OP_RETURN, 32'h0, 32'h5, 32'h0);
		send_op(OP_CALL_CONSTRUCT, 32'h2, 32'h3, 32'h4);
		send_op(OP_CALL_DESTRUCT, 32'h2, 32'h2, 32'h2);
		send_op(OP_CALL_PRUNE, 32'h0, 32'h1, 32'h2);
		send_op(OP_CALL_MODIFY, 32'h5, 32'h6, 32'h7);
		send_op(OP_RETURN, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_op(OP_SUSPEND, 32'h0, 32'h0, 32'h0);
		send_op(OP_UNUSED_LAST, 32'h0, 32'h0, 32'h0);
	endtask

	// The receiver holds ready until a transfer, then may stall for a while.
	always @(posedge clk or negedge arst_n) begin : result_pacing
		int gap;
		int stall;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall = 0;
		end else if (stall != 0) begin
			stall = stall - 1;
			if (stall == 0)
				result_ch.ready <= 1'b1;
		end else if (!result_ch.ready || result_ch.valid) begin
			gap = idle_gap();
			if (gap == 0) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b0;
				stall = gap;
			end
		end
	end

	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("callback_bytecode_execute_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		logic [31:0] store_bases [4];
		logic [31:0] data_bases [4];
		arst_n         <= 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.data  <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= CFG_STORE_BASE;
		cfg_ch.wdata   <= '0;
		sent_items = 0;
		quiet      = 1'b0;
		foreach (value_pool[i])
			value_pool[i] = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 63);
		store_bases = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000};
		data_bases  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom(), 32'h7FFF_FFFF};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_bases(32'h0000_1000, 32'hFFFF_FFF0);
		directed_part();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			set_bases(store_bases[phase], data_bases[phase]);
			while (sent_items < (phase + 1) * PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
				0, 1, 2: call_sequence();
				3, 4, 5: compare_sequence();
				default: random_op();
				endcase
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("callback_bytecode_execute_unit_tb: clean");
		else
			$display("callback_bytecode_execute_unit_tb: errors");
		$finish;
	end

endmodule
